FILE: hdl/lcd_serial_frame_writer_core_defines.svh
// Assertion helpers used by the shifter RTL (lcd_sfw_shifter.sv).
`ifndef LCD_SERIAL_FRAME_WRITER_CORE_DEFINES_SVH
`define LCD_SERIAL_FRAME_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LSFW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LSFW_ASSERT_NEVER(label, expr, msg) \
    `LSFW_ASSERT(label, !(expr), msg)
`else
`define LSFW_ASSERT(label, prop, msg)
`define LSFW_ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: hdl/lcd_sfw_pkg.sv
`default_nettype none

package lcd_sfw_pkg;

    localparam int FRAME_BITS = 24;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);

    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] NIB_MASK  = 8'hF0;

    localparam logic [7:0] ROW1_BASE = 8'h80;
    localparam logic [7:0] ROW2_BASE = 8'h90;
    localparam logic [7:0] ROW3_BASE = 8'h88;
    localparam logic [7:0] ROW4_BASE = 8'h98;

    localparam logic [1:0] ACT_CMD    = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_CURSOR = 2'd2;

    typedef struct packed {
        logic                  vld;
        logic [FRAME_BITS-1:0] frame;
    } t_frame_hs;

    function automatic logic [FRAME_BITS-1:0] pack_frame(
        input logic [7:0] sync,
        input logic [7:0] b
    );
        pack_frame = {sync, b & NIB_MASK, {b[3:0], 4'b0000}};
    endfunction

    function automatic t_frame_hs build_frame(
        input logic [1:0] action,
        input logic [7:0] data_byte,
        input logic [2:0] row,
        input logic [3:0] column
    );
        t_frame_hs  res;
        logic [7:0] base;
        res  = '0;
        base = ROW1_BASE;
        unique case (row)
            3'd1:    base = ROW1_BASE;
            3'd2:    base = ROW2_BASE;
            3'd3:    base = ROW3_BASE;
            3'd4:    base = ROW4_BASE;
            default: base = ROW1_BASE;
        endcase
        unique case (action)
            ACT_CMD: begin
                res.vld   = 1'b1;
                res.frame = pack_frame(SYNC_CMD, data_byte);
            end
            ACT_DATA: begin
                res.vld   = 1'b1;
                res.frame = pack_frame(SYNC_DATA, data_byte);
            end
            ACT_CURSOR: begin
                // rows outside 1..4 produce no frame
                res.vld   = (row >= 3'd1) && (row <= 3'd4);
                res.frame = pack_frame(SYNC_CMD, base + {4'b0000, column});
            end
            default: begin
                res = '0;
            end
        endcase
        build_frame = res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lcd_serial_frame_writer_core.sv
// Serial frame writer for a character LCD controller.
// Input channel (i_valid / o_stall): one request per beat -- write command,
// write data, or set cursor from row 1..4 and column. Cursor requests with
// another row, and unused action codes, are accepted and dropped silently.
// Output channel (o_valid / i_stall): 24 beats per request, the frame MSB
// first on o_sid_bit: sync byte, high nibble, low nibble; o_last marks bit 24.
// o_sid_bit reads high whenever o_valid is low.
// An accepted request is registered in the holding register, then loaded into
// the shifter, which drives the first bit of the frame on o_sid_bit.
// The frame is shifted out by a one-bit-per-beat shifter;
// a second request is held in a one-frame holding register, so the input
// stays open while a frame is shifting and frames go out back to back.
// i_stall freezes the shifter on the current bit; once the holding register
// is full too, o_stall rises until the frame in flight finishes.
// Reset (i_rst_n low, synchronous) drops any frame in flight and the held one.
`default_nettype none

module lcd_serial_frame_writer_core
    import lcd_sfw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [2:0] i_row,
    input  wire logic [3:0] i_column,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_sid_bit,
    output logic            o_last
);

    t_frame_hs pend;
    logic      take;

    lcd_sfw_frame_build u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_row       (i_row),
        .i_column    (i_column),
        .o_pend      (pend),
        .i_take      (take)
    );

    lcd_sfw_shifter u_shift (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pend    (pend),
        .o_take    (take),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_sid_bit (o_sid_bit),
        .o_last    (o_last)
    );

endmodule

`default_nettype wire

FILE: hdl/lcd_sfw_frame_build.sv
`default_nettype none

module lcd_sfw_frame_build
    import lcd_sfw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [2:0] i_row,
    input  wire logic [3:0] i_column,
    output t_frame_hs       o_pend,
    input  wire logic       i_take
);

    logic                  r_vld;
    logic [FRAME_BITS-1:0] r_frame;
    t_frame_hs             n_built;
    logic                  in_acc;

    assign n_built = build_frame(i_action, i_data_byte, i_row, i_column);
    assign o_stall = r_vld && !i_take;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (in_acc && n_built.vld) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_frame <= n_built.frame;
        end
    end

    assign o_pend.vld   = r_vld;
    assign o_pend.frame = r_frame;

endmodule

`default_nettype wire

FILE: hdl/lcd_sfw_shifter.sv
`default_nettype none

`include "lcd_serial_frame_writer_core_defines.svh"

module lcd_sfw_shifter
    import lcd_sfw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_frame_hs i_pend,
    output logic           o_take,
    output logic           o_valid,
    input  wire logic      i_stall,
    output logic           o_sid_bit,
    output logic           o_last
);

    logic                  r_vld;
    logic [CNT_W-1:0]      r_left;
    logic [FRAME_BITS-1:0] r_frame;
    logic                  beat;
    logic                  done;

    assign beat   = r_vld && !i_stall;
    assign done   = beat && (r_left == CNT_W'(1));
    // reload as soon as the shifter is empty or finishing its last beat
    assign o_take = i_pend.vld && (!r_vld || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_left <= '0;
        end else if (o_take) begin
            r_vld  <= 1'b1;
            r_left <= CNT_W'(FRAME_BITS);
        end else if (done) begin
            r_vld  <= 1'b0;
            r_left <= '0;
        end else if (beat) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_frame <= i_pend.frame;
        end else if (beat) begin
            r_frame <= {r_frame[FRAME_BITS-2:0], 1'b0};
        end
    end

    assign o_valid   = r_vld;
    // data line idles high
    assign o_sid_bit = r_vld ? r_frame[FRAME_BITS-1] : 1'b1;
    assign o_last    = r_vld && (r_left == CNT_W'(1));

    `LSFW_ASSERT(a_take_loads, o_take |=> r_vld && (r_left == CNT_W'(FRAME_BITS)), "load lost")
    `LSFW_ASSERT(a_stall_holds,
        r_vld && i_stall |=> $stable(r_left) && $stable(r_frame),
        "shift moved while stalled")
    `LSFW_ASSERT_NEVER(a_left_range,
        r_vld && ((r_left == '0) || (r_left > CNT_W'(FRAME_BITS))),
        "bit count out of range")
    `LSFW_ASSERT(a_last_ends, done && !i_pend.vld |=> !r_vld, "frame ran past last bit")

endmodule

`default_nettype wire
